// File: sv/tqrc_pkg.sv
`default_nettype none
package tqrc_pkg;

  localparam int QUEUE_DEPTH = 4;
  localparam int DIV_STAGES  = 16;

  typedef enum logic [2:0] {
    CFG_OFFSET_X    = 3'd0,
    CFG_OFFSET_Z    = 3'd1,
    CFG_CLIP_LEFT   = 3'd2,
    CFG_CLIP_BOTTOM = 3'd3,
    CFG_CLIP_RIGHT  = 3'd4,
    CFG_CLIP_TOP    = 3'd5
  } cfg_idx_t;

  typedef enum logic [1:0] {
    K_ZERO = 2'b00,
    K_ONE  = 2'b01,
    K_DIV  = 2'b10
  } kmode_t;

  typedef struct packed {
    kmode_t      mode;
    logic [15:0] rem;
    logic [15:0] den;
    logic [15:0] q;
  } step_t;

  typedef struct packed {
    logic [15:0]       left;
    logic [15:0]       bottom;
    logic [15:0]       right;
    logic [15:0]       top;
    logic [3:0][15:0]  u;
    logic [3:0][15:0]  v;
    step_t             sl;
    step_t             sb;
    step_t             sr;
    step_t             st;
  } quad_t;

  // classify one clip step: no move, full move, or fractional ratio
  function automatic step_t step_init(logic act, logic signed [16:0] num,
                                      logic signed [16:0] den);
    step_t s;
    s.rem = num[15:0];
    s.den = den[15:0];
    s.q   = '0;
    if (!act || den <= 17'sd0 || num <= 17'sd0) s.mode = K_ZERO;
    else if (num >= den) s.mode = K_ONE;
    else s.mode = K_DIV;
    return s;
  endfunction

  // one restoring quotient bit
  function automatic step_t div_step(step_t s);
    step_t       o;
    logic [16:0] rem2;
    logic [16:0] diff;
    o    = s;
    rem2 = {s.rem, 1'b0};
    diff = rem2 - {1'b0, s.den};
    if (s.mode == K_DIV) begin
      if (rem2 >= {1'b0, s.den}) begin
        o.rem = diff[15:0];
        o.q   = {s.q[14:0], 1'b1};
      end else begin
        o.rem = rem2[15:0];
        o.q   = {s.q[14:0], 1'b0};
      end
    end
    return o;
  endfunction

  function automatic logic [16:0] ratio(step_t s);
    logic [16:0] k;
    case (s.mode)
      K_ONE:   k = 17'h10000;
      K_DIV:   k = {1'b0, s.q};
      default: k = '0;
    endcase
    return k;
  endfunction

  function automatic logic signed [33:0] lerp_mul(logic [15:0] w, logic [15:0] tgt,
                                                  logic [16:0] k);
    logic signed [16:0] d;
    logic signed [33:0] p;
    d = $signed({1'b0, tgt}) - $signed({1'b0, w});
    p = $signed({1'b0, k}) * d;
    return p;
  endfunction

  // round half up, add, clamp to 16 bits unsigned
  function automatic logic [15:0] lerp_add(logic [15:0] w, logic signed [33:0] p);
    logic signed [33:0] q;
    logic signed [17:0] stp;
    logic signed [18:0] res;
    logic [15:0]        o;
    q   = p + 34'sd32768;
    stp = $signed(q[33:16]);
    res = $signed({3'b000, w}) + stp;
    if (res < 19'sd0) o = '0;
    else if (res > 19'sd65535) o = 16'hFFFF;
    else o = res[15:0];
    return o;
  endfunction

endpackage
`default_nettype wire

// File: sv/textured_quad_rect_clipper.sv
`default_nettype none
// Channel   | Handshake            | Payload
// ----------+----------------------+----------------------------------------
// input     | in_valid / in_ready  | in_left..in_top, in_u0..3, in_v0..3
// result    | out_valid / out_ready| out_left..out_top, out_u0..3, out_v0..3
// config    | cfg_wr_en            | cfg_index, cfg_wdata
//
// One quad per cycle sustained while the output is not stalled. A quad
// goes through 16 divider stages (one quotient bit each, four dividers
// side by side), then multiply and add for left/bottom, then for right/top.
// Reset (rst_n low, synchronous) empties the queue and the pipe and loads
// the clip rectangle defaults. A stalled output holds the whole back pipe;
// the queue keeps taking quads until it is full. Culled quads are accepted
// and dropped in the front without entering the queue.
module textured_quad_rect_clipper #(
  parameter int QUEUE_DEPTH = tqrc_pkg::QUEUE_DEPTH
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic signed [15:0] in_left,
  input  wire logic signed [15:0] in_bottom,
  input  wire logic signed [15:0] in_right,
  input  wire logic signed [15:0] in_top,
  input  wire logic [15:0]       in_u0,
  input  wire logic [15:0]       in_u1,
  input  wire logic [15:0]       in_u2,
  input  wire logic [15:0]       in_u3,
  input  wire logic [15:0]       in_v0,
  input  wire logic [15:0]       in_v1,
  input  wire logic [15:0]       in_v2,
  input  wire logic [15:0]       in_v3,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic signed [15:0]     out_left,
  output logic signed [15:0]     out_bottom,
  output logic signed [15:0]     out_right,
  output logic signed [15:0]     out_top,
  output logic [15:0]            out_u0,
  output logic [15:0]            out_u1,
  output logic [15:0]            out_u2,
  output logic [15:0]            out_u3,
  output logic [15:0]            out_v0,
  output logic [15:0]            out_v1,
  output logic [15:0]            out_v2,
  output logic [15:0]            out_v3,
  input  wire logic              cfg_wr_en,
  input  wire logic [2:0]        cfg_index,
  input  wire logic [15:0]       cfg_wdata
);
  import tqrc_pkg::*;

  logic signed [15:0] offset_x_r, offset_z_r;
  logic signed [15:0] clip_l_r, clip_b_r, clip_r_r, clip_t_r;
  quad_t              front_q, head_q, out_q;
  logic               keep, full, empty, pop, push;

  // registers; the user must write only while the block is idle, unchecked
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      offset_x_r <= '0;
      offset_z_r <= '0;
      clip_l_r   <= '0;
      clip_b_r   <= '0;
      clip_r_r   <= 16'sh7FFF;
      clip_t_r   <= 16'sh7FFF;
    end else if (cfg_wr_en) begin
      case (cfg_idx_t'(cfg_index))
        CFG_OFFSET_X:    offset_x_r <= $signed(cfg_wdata);
        CFG_OFFSET_Z:    offset_z_r <= $signed(cfg_wdata);
        CFG_CLIP_LEFT:   clip_l_r   <= $signed(cfg_wdata);
        CFG_CLIP_BOTTOM: clip_b_r   <= $signed(cfg_wdata);
        CFG_CLIP_RIGHT:  clip_r_r   <= $signed(cfg_wdata);
        CFG_CLIP_TOP:    clip_t_r   <= $signed(cfg_wdata);
        default: ;
      endcase
    end
  end

  // front: offset, cull, classify the four clip steps
  tqrc_front u_front (
    .left     (in_left),
    .bottom   (in_bottom),
    .right    (in_right),
    .top      (in_top),
    .u        ({in_u3, in_u2, in_u1, in_u0}),
    .v        ({in_v3, in_v2, in_v1, in_v0}),
    .offset_x (offset_x_r),
    .offset_z (offset_z_r),
    .clip_l   (clip_l_r),
    .clip_b   (clip_b_r),
    .clip_r   (clip_r_r),
    .clip_t   (clip_t_r),
    .quad     (front_q),
    .keep     (keep)
  );

  // accept while the queue has room; drop culled transactions here
  assign in_ready = !full;
  assign push     = in_valid && in_ready && keep;

  tqrc_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (front_q),
    .full      (full),
    .pop       (pop),
    .empty     (empty),
    .head      (head_q)
  );

  // back: divide, then interpolate UVs in clip order
  tqrc_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (head_q),
    .head_valid (!empty),
    .pop        (pop),
    .out_q      (out_q),
    .out_valid  (out_valid),
    .out_ready  (out_ready)
  );

  assign out_left   = $signed(out_q.left);
  assign out_bottom = $signed(out_q.bottom);
  assign out_right  = $signed(out_q.right);
  assign out_top    = $signed(out_q.top);
  assign out_u0     = out_q.u[0];
  assign out_u1     = out_q.u[1];
  assign out_u2     = out_q.u[2];
  assign out_u3     = out_q.u[3];
  assign out_v0     = out_q.v[0];
  assign out_v1     = out_q.v[1];
  assign out_v2     = out_q.v[2];
  assign out_v3     = out_q.v[3];

endmodule
`default_nettype wire

// File: sv/tqrc_front.sv
`default_nettype none
module tqrc_front (
  input  wire logic signed [15:0] left,
  input  wire logic signed [15:0] bottom,
  input  wire logic signed [15:0] right,
  input  wire logic signed [15:0] top,
  input  wire logic [3:0][15:0]   u,
  input  wire logic [3:0][15:0]   v,
  input  wire logic signed [15:0] offset_x,
  input  wire logic signed [15:0] offset_z,
  input  wire logic signed [15:0] clip_l,
  input  wire logic signed [15:0] clip_b,
  input  wire logic signed [15:0] clip_r,
  input  wire logic signed [15:0] clip_t,
  output tqrc_pkg::quad_t         quad,
  output logic                    keep
);
  import tqrc_pkg::*;

  function automatic logic signed [16:0] sat_add(logic signed [15:0] a,
                                                 logic signed [15:0] b);
    logic signed [16:0] s;
    s = 17'(a) + 17'(b);
    if (s > 17'sd32767) s = 17'sd32767;
    else if (s < -17'sd32768) s = -17'sd32768;
    return s;
  endfunction

  logic signed [16:0] l, b, r, t, cl, cb, cr, ct, l2, b2;
  logic               act_l, act_b, act_r, act_t;

  always_comb begin
    l  = sat_add(left, offset_x);
    r  = sat_add(right, offset_x);
    b  = sat_add(bottom, offset_z);
    t  = sat_add(top, offset_z);
    cl = 17'(clip_l);
    cb = 17'(clip_b);
    cr = 17'(clip_r);
    ct = 17'(clip_t);
    keep  = !(l > cr || r < cl || b > ct || t < cb);
    act_l = l < cl;
    act_b = b < cb;
    act_r = r > cr;
    act_t = t > ct;
    // right and top see the edge already moved by left and bottom
    l2 = act_l ? cl : l;
    b2 = act_b ? cb : b;
    quad.left   = l2[15:0];
    quad.bottom = b2[15:0];
    quad.right  = act_r ? cr[15:0] : r[15:0];
    quad.top    = act_t ? ct[15:0] : t[15:0];
    quad.u  = u;
    quad.v  = v;
    quad.sl = step_init(act_l, cl - l, r - l);
    quad.sb = step_init(act_b, cb - b, t - b);
    quad.sr = step_init(act_r, r - cr, r - l2);
    quad.st = step_init(act_t, t - ct, t - b2);
  end

endmodule
`default_nettype wire

// File: sv/tqrc_queue.sv
`default_nettype none
module tqrc_queue #(
  parameter int DEPTH = tqrc_pkg::QUEUE_DEPTH
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push,
  input  wire tqrc_pkg::quad_t push_data,
  output logic                full,
  input  wire logic           pop,
  output logic                empty,
  output tqrc_pkg::quad_t     head
);
  import tqrc_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  quad_t           mem [DEPTH];
  logic [AW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [AW:0]     count_r;
  logic            do_pop;

  assign full   = count_r == (AW+1)'(DEPTH);
  assign empty  = count_r == '0;
  assign head   = mem[rd_ptr_r];
  assign do_pop = pop && !empty;

  function automatic logic [AW-1:0] bump(logic [AW-1:0] p);
    return (p == AW'(DEPTH-1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= bump(wr_ptr_r);
      if (do_pop) rd_ptr_r <= bump(rd_ptr_r);
      if (push && !do_pop) count_r <= count_r + 1'b1;
      else if (!push && do_pop) count_r <= count_r - 1'b1;
    end
  end

endmodule
`default_nettype wire

// File: sv/tqrc_back.sv
`default_nettype none
module tqrc_back (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire tqrc_pkg::quad_t head,
  input  wire logic            head_valid,
  output logic                 pop,
  output tqrc_pkg::quad_t      out_q,
  output logic                 out_valid,
  input  wire logic            out_ready
);
  import tqrc_pkg::*;

  quad_t                 div_r [DIV_STAGES];
  logic [DIV_STAGES-1:0] dv_r;
  quad_t                 ma_r, aa_r, mb_r, ob_r;
  logic                  ma_v_r, aa_v_r, mb_v_r, ob_v_r;
  logic signed [33:0]    pa_r [4];
  logic signed [33:0]    pb_r [4];
  logic                  en;
  logic [16:0]           k_l, k_b, k_r, k_t;

  // the whole back pipe advances together unless the output is stalled
  assign en        = !ob_v_r || out_ready;
  assign pop       = en && head_valid;
  assign out_q     = ob_r;
  assign out_valid = ob_v_r;

  assign k_l = ratio(div_r[DIV_STAGES-1].sl);
  assign k_b = ratio(div_r[DIV_STAGES-1].sb);
  assign k_r = ratio(aa_r.sr);
  assign k_t = ratio(aa_r.st);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_r   <= '0;
      ma_v_r <= 1'b0;
      aa_v_r <= 1'b0;
      mb_v_r <= 1'b0;
      ob_v_r <= 1'b0;
    end else if (en) begin
      dv_r   <= {dv_r[DIV_STAGES-2:0], head_valid};
      ma_v_r <= dv_r[DIV_STAGES-1];
      aa_v_r <= ma_v_r;
      mb_v_r <= aa_v_r;
      ob_v_r <= mb_v_r;
    end
  end

  always_ff @(posedge clk) begin
    quad_t d;
    if (en) begin
      d = head;
      d.sl = div_step(head.sl);
      d.sb = div_step(head.sb);
      d.sr = div_step(head.sr);
      d.st = div_step(head.st);
      div_r[0] <= d;
      for (int i = 1; i < DIV_STAGES; i++) begin
        d = div_r[i-1];
        d.sl = div_step(div_r[i-1].sl);
        d.sb = div_step(div_r[i-1].sb);
        d.sr = div_step(div_r[i-1].sr);
        d.st = div_step(div_r[i-1].st);
        div_r[i] <= d;
      end

      // left and bottom
      ma_r    <= div_r[DIV_STAGES-1];
      pa_r[0] <= lerp_mul(div_r[DIV_STAGES-1].u[0], div_r[DIV_STAGES-1].u[1], k_l);
      pa_r[1] <= lerp_mul(div_r[DIV_STAGES-1].u[3], div_r[DIV_STAGES-1].u[2], k_l);
      pa_r[2] <= lerp_mul(div_r[DIV_STAGES-1].v[0], div_r[DIV_STAGES-1].v[3], k_b);
      pa_r[3] <= lerp_mul(div_r[DIV_STAGES-1].v[1], div_r[DIV_STAGES-1].v[2], k_b);

      d = ma_r;
      d.u[0] = lerp_add(ma_r.u[0], pa_r[0]);
      d.u[3] = lerp_add(ma_r.u[3], pa_r[1]);
      d.v[0] = lerp_add(ma_r.v[0], pa_r[2]);
      d.v[1] = lerp_add(ma_r.v[1], pa_r[3]);
      aa_r <= d;

      // right and top use the values left and bottom produced
      mb_r    <= aa_r;
      pb_r[0] <= lerp_mul(aa_r.u[2], aa_r.u[3], k_r);
      pb_r[1] <= lerp_mul(aa_r.u[1], aa_r.u[0], k_r);
      pb_r[2] <= lerp_mul(aa_r.v[2], aa_r.v[1], k_t);
      pb_r[3] <= lerp_mul(aa_r.v[3], aa_r.v[0], k_t);

      d = mb_r;
      d.u[2] = lerp_add(mb_r.u[2], pb_r[0]);
      d.u[1] = lerp_add(mb_r.u[1], pb_r[1]);
      d.v[2] = lerp_add(mb_r.v[2], pb_r[2]);
      d.v[3] = lerp_add(mb_r.v[3], pb_r[3]);
      ob_r <= d;
    end
  end

endmodule
`default_nettype wire

// File: sv/tqrc_checker.sv
`default_nettype none
module tqrc_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [15:0] out_left,
  input wire logic [15:0] out_u0
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_left) && $stable(out_u0))
    else $error("result changed while stalled");

  // reset empties pipe and queue
  a_rst_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_rst_ready: assert property (@(posedge clk) !rst_n |=> in_ready)
    else $error("not ready right after reset");

endmodule

bind textured_quad_rect_clipper tqrc_checker u_tqrc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_left  (out_left),
  .out_u0    (out_u0)
);
`default_nettype wire
